// ===== design/ckeng_pkg.sv =====
package ckeng_pkg;

    localparam logic [15:0] WORD_ONES      = 16'hFFFF;
    localparam logic [15:0] PROTO_TCP_WORD = 16'h0006;
    localparam logic [15:0] ODD_BYTE_MASK  = 16'hFF00;
    localparam logic [4:0]  ADDR_FIRST_IDX = 5'd6;
    localparam logic [4:0]  ADDR_LAST_IDX  = 5'd9;
    localparam logic [4:0]  HDR_IDX_MAX    = 5'd31;
    localparam int          QUEUE_DEPTH    = 4;

    localparam logic KIND_IP  = 1'b0;
    localparam logic KIND_TCP = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [15:0] word;
        logic        odd_byte;
        logic        last;
    } in_item_t;

    typedef struct packed {
        logic [15:0] sum_value;
        logic        which;
    } out_item_t;

    // Classified word as it travels from the front end to the accumulators.
    typedef struct packed {
        logic        kind;
        logic [15:0] word;
        logic        addr_word;
        logic        odd_byte;
        logic        last;
    } cls_item_t;

    // Ones' complement sum of four words with end-around carry.
    function automatic logic [15:0] oc_sum4(input logic [15:0] a, input logic [15:0] b,
                                           input logic [15:0] c, input logic [15:0] d);
        logic [17:0] s;
        logic [16:0] f;
        s = {2'b00, a} + {2'b00, b} + {2'b00, c} + {2'b00, d};
        f = {1'b0, s[15:0]} + {15'd0, s[17:16]};
        return f[15:0] + {15'd0, f[16]};
    endfunction

    function automatic logic [15:0] finish(input logic [15:0] c);
        return (c == WORD_ONES) ? WORD_ONES : ~c;
    endfunction

endpackage

// ===== design/ckeng_front.sv =====
module ckeng_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  ckeng_pkg::in_item_t   item,
    output ckeng_pkg::cls_item_t  cls
);
    import ckeng_pkg::*;

    logic [4:0] hdr_idx_reg;
    logic [4:0] hdr_idx_next;

    // Position within the IP header decides which words also feed the TCP sum.
    always_comb
    begin
        cls.kind      = item.kind;
        cls.word      = item.odd_byte ? (item.word & ODD_BYTE_MASK) : item.word;
        cls.addr_word = (item.kind == KIND_IP) && (hdr_idx_reg >= ADDR_FIRST_IDX)
                        && (hdr_idx_reg <= ADDR_LAST_IDX);
        cls.odd_byte  = item.odd_byte;
        cls.last      = item.last;

        hdr_idx_next = hdr_idx_reg;
        if (accept && (item.kind == KIND_IP))
        begin
            if (item.last)
                hdr_idx_next = '0;
            else if (hdr_idx_reg < HDR_IDX_MAX)
                hdr_idx_next = hdr_idx_reg + 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hdr_idx_reg <= '0;
        else
            hdr_idx_reg <= hdr_idx_next;
    end

endmodule

// ===== design/ckeng_fifo.sv =====
module ckeng_fifo #(
    parameter int DEPTH = ckeng_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  ckeng_pkg::cls_item_t  wr_data,
    output logic                  full,
    input  logic                  rd_en,
    output ckeng_pkg::cls_item_t  rd_data,
    output logic                  empty
);
    import ckeng_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    cls_item_t     slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_wr;
    logic          do_rd;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PW'(1);
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PW'(1);
            if (do_wr && !do_rd)
                count_reg <= count_reg + CW'(1);
            else if (do_rd && !do_wr)
                count_reg <= count_reg - CW'(1);
        end
    end

endmodule

// ===== design/ckeng_back.sv =====
module ckeng_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_empty,
    input  ckeng_pkg::cls_item_t  q_item,
    output logic                  q_pop,
    output logic                  empty,
    input  logic                  pop,
    output ckeng_pkg::out_item_t  result
);
    import ckeng_pkg::*;

    logic [15:0] hdr_sum_reg;
    logic [15:0] hdr_sum_next;
    logic [15:0] seg_sum_reg;
    logic [15:0] seg_sum_next;
    logic [15:0] byte_cnt_reg;
    logic [15:0] byte_cnt_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    out_item_t   out_reg;
    out_item_t   out_next;
    logic [16:0] cnt_sum;
    logic [15:0] cnt_sat;
    logic [15:0] hdr_add;
    logic [15:0] seg_add;
    logic        slot_free;

    // A word without a result never waits; a last word needs the output slot.
    assign slot_free = !out_valid_reg || pop;
    assign q_pop     = !q_empty && (!q_item.last || slot_free);
    assign empty     = !out_valid_reg;
    assign result    = out_reg;

    always_comb
    begin
        cnt_sum = {1'b0, byte_cnt_reg} + (q_item.odd_byte ? 17'd1 : 17'd2);
        cnt_sat = cnt_sum[16] ? WORD_ONES : cnt_sum[15:0];
        hdr_add = oc_sum4(hdr_sum_reg, q_item.word, 16'd0, 16'd0);
        seg_add = oc_sum4(seg_sum_reg, q_item.word, 16'd0, 16'd0);

        hdr_sum_next   = hdr_sum_reg;
        seg_sum_next   = seg_sum_reg;
        byte_cnt_next  = byte_cnt_reg;
        out_valid_next = out_valid_reg && !pop;
        out_next       = out_reg;

        if (q_pop)
        begin
            if (q_item.kind == KIND_IP)
            begin
                hdr_sum_next = hdr_add;
                if (q_item.addr_word)
                    seg_sum_next = seg_add;
                if (q_item.last)
                begin
                    out_next.sum_value = finish(hdr_add);
                    out_next.which     = KIND_IP;
                    out_valid_next     = 1'b1;
                    hdr_sum_next       = '0;
                end
            end
            else
            begin
                seg_sum_next  = seg_add;
                byte_cnt_next = cnt_sat;
                if (q_item.last)
                begin
                    out_next.sum_value = finish(oc_sum4(seg_sum_reg, q_item.word,
                                                        PROTO_TCP_WORD, cnt_sat));
                    out_next.which     = KIND_TCP;
                    out_valid_next     = 1'b1;
                    seg_sum_next       = '0;
                    byte_cnt_next      = '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_sum_reg   <= '0;
            seg_sum_reg   <= '0;
            byte_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            hdr_sum_reg   <= hdr_sum_next;
            seg_sum_reg   <= seg_sum_next;
            byte_cnt_reg  <= byte_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== design/ipv4_tcp_checksum_engine_core.sv =====
// Channel   Handshake             Payload
// item      push / full           in_item_t  (kind, word, odd_byte, last)
// result    empty / pop           out_item_t (sum_value, which)
//
// One packet word is taken per cycle while the queue is not full. A word is
// classified on entry and summed after it leaves the queue.
// A checksum is registered in the result slot at the edge at which its last
// word is summed.
// A result not yet taken holds the next last word at the head of the queue;
// the words behind it wait in the queue. Words before it keep flowing.
// Reset clears all sums, counters, the queue and the result slot.
module ipv4_tcp_checksum_engine_core #(
    parameter int QUEUE_DEPTH = ckeng_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  ckeng_pkg::in_item_t   item,
    output logic                  empty,
    input  logic                  pop,
    output ckeng_pkg::out_item_t  result
);
    import ckeng_pkg::*;

    cls_item_t cls_item;
    cls_item_t q_item;
    logic      q_empty;
    logic      q_pop;
    logic      accept;

    assign accept = push && !full;

    ckeng_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .cls    (cls_item)
    );

    ckeng_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_data (cls_item),
        .full    (full),
        .rd_en   (q_pop),
        .rd_data (q_item),
        .empty   (q_empty)
    );

    ckeng_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule
